### sv/gbpf_pkg.sv
`default_nettype none

package gbpf_pkg;

	// Default geometry of the font and the frame.
	localparam int GLYPH_COUNT_DEF   = 96;
	localparam int GLYPH_COLUMNS_DEF = 12;
	localparam int GLYPH_STRIDE_DEF  = 25;
	localparam int PAGE_WIDTH_DEF    = 128;

	// Widths of the item fields.
	localparam int OP_W     = 3;
	localparam int FADDR_W  = 12;
	localparam int BYTE_W   = 8;
	localparam int FRADDR_W = 9;
	localparam int CURSOR_W = 8;
	// A cursor plus a glyph column index (at most GLYPH_COLUMNS_DEF - 1) fits one bit more.
	localparam int POS_W    = CURSOR_W + 1;

	// Character code of the first glyph and the cursor ceiling.
	localparam logic [BYTE_W-1:0]   FIRST_CODE = 8'd32;
	localparam logic [CURSOR_W-1:0] CURSOR_MAX = 8'd255;

	typedef logic [OP_W-1:0] op_t;

	localparam op_t OP_LOAD  = 3'd0;
	localparam op_t OP_DRAW  = 3'd1;
	localparam op_t OP_SET   = 3'd2;
	localparam op_t OP_CLEAR = 3'd3;
	localparam op_t OP_READ  = 3'd4;

	// Font byte write from the command side.
	typedef struct packed {
		logic               en;
		logic [FADDR_W-1:0] addr;
		logic [BYTE_W-1:0]  data;
	} font_wr_t;

	// Frame write control: one text row, or both rows during a clear.
	typedef struct packed {
		logic en;
		logic both;
		logic row;
	} frame_ctl_t;

endpackage

`default_nettype wire

### sv/gbpf_cmd_if.sv
`default_nettype none

interface gbpf_cmd_if;
	import gbpf_pkg::*;

	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [FADDR_W-1:0]  font_address;
	logic [BYTE_W-1:0]   font_byte;
	logic                text_row;
	logic [BYTE_W-1:0]   symbol;
	logic [CURSOR_W-1:0] cursor_column;
	logic [FRADDR_W-1:0] frame_address;

	modport source (
		output valid, operation, font_address, font_byte, text_row, symbol,
			cursor_column, frame_address,
		input  ready
	);

	modport sink (
		input  valid, operation, font_address, font_byte, text_row, symbol,
			cursor_column, frame_address,
		output ready
	);

endinterface

`default_nettype wire

### sv/gbpf_res_if.sv
`default_nettype none

interface gbpf_res_if;
	import gbpf_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   read_byte;
	logic [CURSOR_W-1:0] row_zero_cursor;
	logic [CURSOR_W-1:0] row_one_cursor;
	logic                glyph_drawn;

	modport source (
		output valid, read_byte, row_zero_cursor, row_one_cursor, glyph_drawn,
		input  ready
	);

	modport sink (
		input  valid, read_byte, row_zero_cursor, row_one_cursor, glyph_drawn,
		output ready
	);

endinterface

`default_nettype wire

### sv/gbpf_font_store.sv
`default_nettype none

module gbpf_font_store #(
	parameter int FONT_SIZE = 2400,
	parameter int RA_W      = 12
) (
	input  wire logic                         clk,
	input  wire gbpf_pkg::font_wr_t           wr,
	input  wire logic [RA_W-1:0]              rd_addr,
	output logic      [gbpf_pkg::BYTE_W-1:0]  first_byte,
	output logic      [gbpf_pkg::BYTE_W-1:0]  second_byte
);
	import gbpf_pkg::*;

	// The store is split into even and odd byte banks, so that two
	// consecutive bytes come out in the same cycle.
	localparam int BANK_DEPTH = (FONT_SIZE + 1) / 2;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int WA_W       = BANK_AW + 1;

	logic [BYTE_W-1:0] even_mem [BANK_DEPTH];
	logic [BYTE_W-1:0] odd_mem  [BANK_DEPTH];

	logic              wr_ok;
	logic [WA_W-1:0]   wr_a;
	logic [RA_W-1:0]   even_idx;
	logic [RA_W-1:0]   odd_idx;
	logic [RA_W:0]     next_addr;
	logic [BYTE_W-1:0] even_q;
	logic [BYTE_W-1:0] odd_q;
	logic              lsb_q;
	logic              first_ok_q;
	logic              second_ok_q;

	// Loads past the end of the store are dropped.
	assign wr_ok = wr.en && (32'(wr.addr) < 32'(FONT_SIZE));
	assign wr_a  = WA_W'(wr.addr);

	always_ff @(posedge clk) begin
		if (wr_ok && wr_a[0]) begin
			odd_mem[wr_a[WA_W-1:1]] <= wr.data;
		end
		if (wr_ok && !wr_a[0]) begin
			even_mem[wr_a[WA_W-1:1]] <= wr.data;
		end
	end

	// An odd start address takes its second byte from the next even row.
	assign odd_idx   = rd_addr >> 1;
	assign even_idx  = (rd_addr >> 1) + RA_W'(rd_addr[0]);
	assign next_addr = (RA_W + 1)'(rd_addr) + (RA_W + 1)'(1);

	always_ff @(posedge clk) begin
		even_q      <= even_mem[even_idx[BANK_AW-1:0]];
		odd_q       <= odd_mem[odd_idx[BANK_AW-1:0]];
		lsb_q       <= rd_addr[0];
		first_ok_q  <= 32'(rd_addr) < 32'(FONT_SIZE);
		second_ok_q <= 32'(next_addr) < 32'(FONT_SIZE);
	end

	// Bytes beyond the store end read as zero.
	assign first_byte  = !first_ok_q ? '0 : (lsb_q ? odd_q : even_q);
	assign second_byte = !second_ok_q ? '0 : (lsb_q ? even_q : odd_q);

endmodule

`default_nettype wire

### sv/gbpf_frame_store.sv
`default_nettype none

module gbpf_frame_store #(
	parameter int PAGE_WIDTH = 128,
	parameter int COL_W      = 7
) (
	input  wire logic                          clk,
	input  wire gbpf_pkg::frame_ctl_t          ctl,
	input  wire logic [COL_W-1:0]              wr_col,
	input  wire logic [2*gbpf_pkg::BYTE_W-1:0] wr_data,
	input  wire logic [COL_W-1:0]              rd_col,
	output logic      [2*gbpf_pkg::BYTE_W-1:0] rd_row0,
	output logic      [2*gbpf_pkg::BYTE_W-1:0] rd_row1
);
	import gbpf_pkg::*;

	// One memory per text row; a word holds the lower page byte over the
	// upper page byte of one column.
	logic [2*BYTE_W-1:0] row0_mem [PAGE_WIDTH];
	logic [2*BYTE_W-1:0] row1_mem [PAGE_WIDTH];

	always_ff @(posedge clk) begin
		if (ctl.en && (ctl.both || !ctl.row)) begin
			row0_mem[wr_col] <= wr_data;
		end
		if (ctl.en && (ctl.both || ctl.row)) begin
			row1_mem[wr_col] <= wr_data;
		end
		rd_row0 <= row0_mem[rd_col];
		rd_row1 <= row1_mem[rd_col];
	end

endmodule

`default_nettype wire

### sv/glyph_blit_page_framebuffer.sv
`default_nettype none

// Glyph blitter into a four-page frame buffer with a loadable bitmap font.
// Items arrive on cmd (valid/ready) and each gives exactly one result item
// on res (valid/ready) carrying the read byte, both row cursors and the
// drawn flag. The block takes one item at a time; cmd.ready is high only
// while the sequencer is idle.
// Steps from acceptance to the result being offered:
//   load, set cursor, unused codes, undrawable symbols: the finish state
//   read frame byte: the read state, then the finish state
//   draw glyph: the draw walk at one font read per cycle, first the
//     advance width, then one column pair per read; then drain and finish
//   clear frame: one frame column per cycle, then the finish state.
// cmd.ready comes back in the cycle the result is offered.
// After reset is released the frame is swept to zero column by column
// before the first item is taken. The font is undefined until loaded.
// A result waits in an output register while res.ready is low; the next
// item may already be accepted, but its result is held back until the
// previous one has been taken.
module glyph_blit_page_framebuffer #(
	parameter int GLYPH_COUNT   = gbpf_pkg::GLYPH_COUNT_DEF,
	parameter int GLYPH_COLUMNS = gbpf_pkg::GLYPH_COLUMNS_DEF,
	parameter int GLYPH_STRIDE  = gbpf_pkg::GLYPH_STRIDE_DEF,
	parameter int PAGE_WIDTH    = gbpf_pkg::PAGE_WIDTH_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	gbpf_cmd_if.sink  cmd,
	gbpf_res_if.source res
);
	import gbpf_pkg::*;

	localparam int FONT_SIZE = GLYPH_COUNT * GLYPH_STRIDE;
	localparam int RA_W      = $clog2(FONT_SIZE + 2 * GLYPH_COLUMNS + 1);
	localparam int COL_W     = $clog2(PAGE_WIDTH);
	localparam int CNT_W     = $clog2(GLYPH_COLUMNS + 1);
	localparam int FR_W      = $clog2(4 * PAGE_WIDTH + 1);
	localparam int EXT_W     = (FR_W > FRADDR_W) ? FR_W : FRADDR_W;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_DRAW   = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_READ   = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0]          state_q;
	logic                accept;
	logic [OP_W-1:0]     op_q;
	logic                row_q;
	logic [CURSOR_W-1:0] cur_q;
	logic [CURSOR_W-1:0] cur0_q;
	logic [CURSOR_W-1:0] cur1_q;
	logic                drawn_q;
	logic                clr_reply_q;
	logic [COL_W-1:0]    clr_q;
	logic [CNT_W-1:0]    step_q;
	logic [RA_W-1:0]     fa_q;
	logic                s1_valid_q;
	logic                s1_width_q;
	logic [CNT_W-1:0]    s1_col_q;

	logic [BYTE_W-1:0]   glyph_idx;
	logic                glyph_ok;
	logic [RA_W-1:0]     glyph_base;

	logic [EXT_W-1:0]    fa_x;
	logic [1:0]          page;
	logic [EXT_W-1:0]    page_off;
	logic [EXT_W-1:0]    col_x;
	logic [COL_W-1:0]    rd_col_q;
	logic [1:0]          rd_page_q;
	logic                rd_ok_q;

	font_wr_t            font_wr;
	logic [BYTE_W-1:0]   font_first;
	logic [BYTE_W-1:0]   font_second;

	frame_ctl_t          frame_ctl;
	logic [COL_W-1:0]    frame_wr_col;
	logic [2*BYTE_W-1:0] frame_wr_data;
	logic [2*BYTE_W-1:0] frame_row0;
	logic [2*BYTE_W-1:0] frame_row1;
	logic [2*BYTE_W-1:0] frame_word;
	logic [BYTE_W-1:0]   frame_byte;

	logic [POS_W-1:0]    pos;
	logic [POS_W-1:0]    next_cur;
	logic [CURSOR_W-1:0] sat_cur;
	logic                res_load;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	// Glyph lookup: codes below the first glyph or past the font are skipped.
	assign glyph_idx  = cmd.symbol - FIRST_CODE;
	assign glyph_ok   = (cmd.symbol >= FIRST_CODE) &&
		({1'b0, glyph_idx} < (BYTE_W + 1)'(GLYPH_COUNT));
	assign glyph_base = RA_W'(glyph_idx) * RA_W'(GLYPH_STRIDE);

	// Split a frame address into page and column with three compares.
	assign fa_x = EXT_W'(cmd.frame_address);

	always_comb begin
		priority if (fa_x >= EXT_W'(3 * PAGE_WIDTH)) begin
			page     = 2'd3;
			page_off = EXT_W'(3 * PAGE_WIDTH);
		end else if (fa_x >= EXT_W'(2 * PAGE_WIDTH)) begin
			page     = 2'd2;
			page_off = EXT_W'(2 * PAGE_WIDTH);
		end else if (fa_x >= EXT_W'(PAGE_WIDTH)) begin
			page     = 2'd1;
			page_off = EXT_W'(PAGE_WIDTH);
		end else begin
			page     = 2'd0;
			page_off = '0;
		end
	end

	assign col_x = fa_x - page_off;

	// Font loads go straight into the store at acceptance.
	always_comb begin
		font_wr.en   = accept && (cmd.operation == OP_LOAD);
		font_wr.addr = cmd.font_address;
		font_wr.data = cmd.font_byte;
	end

	gbpf_font_store #(
		.FONT_SIZE(FONT_SIZE),
		.RA_W     (RA_W)
	) u_font (
		.clk        (clk),
		.wr         (font_wr),
		.rd_addr    (fa_q),
		.first_byte (font_first),
		.second_byte(font_second)
	);

	// Second draw stage: place the column pair, or advance the cursor.
	assign pos      = POS_W'(cur_q) + POS_W'(s1_col_q);
	assign next_cur = POS_W'(cur_q) + POS_W'(font_first);
	assign sat_cur  = next_cur[POS_W-1] ? CURSOR_MAX : next_cur[CURSOR_W-1:0];

	always_comb begin
		if (state_q == ST_CLEAR) begin
			frame_ctl.en   = 1'b1;
			frame_ctl.both = 1'b1;
			frame_ctl.row  = 1'b0;
			frame_wr_col   = clr_q;
			frame_wr_data  = '0;
		end else begin
			frame_ctl.en   = s1_valid_q && !s1_width_q &&
				(pos < POS_W'(PAGE_WIDTH));
			frame_ctl.both = 1'b0;
			frame_ctl.row  = row_q;
			frame_wr_col   = pos[COL_W-1:0];
			frame_wr_data  = {font_second, font_first};
		end
	end

	gbpf_frame_store #(
		.PAGE_WIDTH(PAGE_WIDTH),
		.COL_W     (COL_W)
	) u_frame (
		.clk    (clk),
		.ctl    (frame_ctl),
		.wr_col (frame_wr_col),
		.wr_data(frame_wr_data),
		.rd_col (rd_col_q),
		.rd_row0(frame_row0),
		.rd_row1(frame_row1)
	);

	// Upper page of a row sits in the high byte of the word.
	assign frame_word = rd_page_q[1] ? frame_row1 : frame_row0;
	assign frame_byte = rd_page_q[0] ? frame_word[2*BYTE_W-1:BYTE_W]
		: frame_word[BYTE_W-1:0];

	assign res_load = (state_q == ST_FINISH) && (!res.valid || res.ready);

	// Sequencer and cursors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			clr_reply_q <= 1'b0;
			step_q      <= '0;
			s1_valid_q  <= 1'b0;
			cur0_q      <= '0;
			cur1_q      <= '0;
		end else begin
			s1_valid_q <= (state_q == ST_DRAW);

			if (s1_valid_q && s1_width_q) begin
				if (row_q) begin
					cur1_q <= sat_cur;
				end else begin
					cur0_q <= sat_cur;
				end
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == COL_W'(PAGE_WIDTH - 1)) begin
						clr_q   <= '0;
						state_q <= clr_reply_q ? ST_FINISH : ST_IDLE;
					end else begin
						clr_q <= clr_q + COL_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd.operation)
							OP_DRAW: begin
								state_q <= glyph_ok ? ST_DRAW : ST_FINISH;
								step_q  <= '0;
							end
							OP_SET: begin
								if (cmd.text_row) begin
									cur1_q <= cmd.cursor_column;
								end else begin
									cur0_q <= cmd.cursor_column;
								end
								state_q <= ST_FINISH;
							end
							OP_CLEAR: begin
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLEAR;
							end
							OP_READ: begin
								state_q <= ST_READ;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_DRAW: begin
					if (step_q == CNT_W'(GLYPH_COLUMNS)) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (res_load) begin
						clr_reply_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item context and the font read address for the draw walk.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= cmd.operation;
			row_q     <= cmd.text_row;
			cur_q     <= cmd.text_row ? cur1_q : cur0_q;
			drawn_q   <= (cmd.operation == OP_DRAW) && glyph_ok;
			fa_q      <= glyph_base;
			rd_col_q  <= col_x[COL_W-1:0];
			rd_page_q <= page;
			rd_ok_q   <= fa_x < EXT_W'(4 * PAGE_WIDTH);
		end else if (state_q == ST_DRAW) begin
			// The advance width is one byte; each column pair is two.
			fa_q <= fa_q + ((step_q == '0) ? RA_W'(1) : RA_W'(2));
		end
		s1_width_q <= (step_q == '0);
		s1_col_q   <= step_q - CNT_W'(1);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (res_load) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res.read_byte       <= ((op_q == OP_READ) && rd_ok_q) ? frame_byte : '0;
			res.row_zero_cursor <= cur0_q;
			res.row_one_cursor  <= cur1_q;
			res.glyph_drawn     <= drawn_q;
		end
	end

endmodule

`default_nettype wire

### verif/glyph_blit_page_framebuffer_test.sv
`timescale 1ns / 1ps

module glyph_blit_page_framebuffer_test;
	import gbpf_pkg::*;

	localparam int FONT_BYTES    = GLYPH_COUNT_DEF * GLYPH_STRIDE_DEF;
	localparam int FRAME_BYTES   = 4 * PAGE_WIDTH_DEF;
	localparam int QUIET_LIMIT   = 3000;
	localparam int DRAIN_CYCLES  = 40;
	localparam int ITEM_TARGET   = 550;
	localparam int REPORT_LIMIT  = 10;

	// Operation codes the block leaves unused.
	localparam op_t OP_SPARE_FIRST = 3'd5;
	localparam op_t OP_SPARE_LAST  = 3'd7;

	typedef struct packed {
		op_t                 op;
		logic [FADDR_W-1:0]  font_addr;
		logic [BYTE_W-1:0]   font_data;
		logic                row;
		logic [BYTE_W-1:0]   code;
		logic [CURSOR_W-1:0] column;
		logic [FRADDR_W-1:0] frame_addr;
	} blit_cmd_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   rd_byte;
		logic [CURSOR_W-1:0] cursor0;
		logic [CURSOR_W-1:0] cursor1;
		logic                drawn;
	} blit_result_t;

	logic clk;
	logic arst_n;

	gbpf_cmd_if cmd ();
	gbpf_res_if res ();

	glyph_blit_page_framebuffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	// Shadow copy of the block's state.
	logic [BYTE_W-1:0]   font_mem [FONT_BYTES];
	bit                  font_loaded [FONT_BYTES];
	logic [BYTE_W-1:0]   frame_mem [FRAME_BYTES];
	logic [CURSOR_W-1:0] row_cursor [2];

	blit_result_t pending_results [$];
	blit_result_t want;

	bit idling = 1'b1;
	int stall_left = 0;
	int items_sent = 0;
	int results_seen = 0;
	int mismatches = 0;

	// Tallies for the closing summary.
	int n_load, n_draw, n_skip, n_clip, n_sat, n_set, n_clear, n_read, n_spare;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit in_font(logic [BYTE_W-1:0] code);
		return code >= FIRST_CODE && (code - FIRST_CODE) < GLYPH_COUNT_DEF;
	endfunction

	// A glyph may be drawn only once all of its bytes have been loaded.
	function automatic bit glyph_ready(int g);
		for (int i = 0; i < GLYPH_STRIDE_DEF; i++)
			if (!font_loaded[g * GLYPH_STRIDE_DEF + i]) return 1'b0;
		return 1'b1;
	endfunction

	// Applies one command to the shadow state and returns its result.
	function automatic blit_result_t blit_step(blit_cmd_t it);
		blit_result_t r;
		int unsigned base, upper, cur, nxt;
		r = '0;
		case (it.op)
			OP_LOAD: begin
				n_load++;
				if (it.font_addr < FONT_BYTES) begin
					font_mem[it.font_addr] = it.font_data;
					font_loaded[it.font_addr] = 1'b1;
				end
			end
			OP_DRAW: begin
				if (in_font(it.code)) begin
					n_draw++;
					base = (it.code - FIRST_CODE) * GLYPH_STRIDE_DEF;
					upper = it.row ? 2 * PAGE_WIDTH_DEF : 0;
					cur = row_cursor[it.row];
					if (cur + GLYPH_COLUMNS_DEF > PAGE_WIDTH_DEF) n_clip++;
					for (int c = 0; c < GLYPH_COLUMNS_DEF; c++) begin
						if (cur + c < PAGE_WIDTH_DEF) begin
							frame_mem[upper + cur + c] = font_mem[base + 2 * c + 1];
							frame_mem[upper + PAGE_WIDTH_DEF + cur + c] =
								font_mem[base + 2 * c + 2];
						end
					end
					nxt = cur + font_mem[base];
					if (nxt > CURSOR_MAX) begin
						nxt = CURSOR_MAX;
						n_sat++;
					end
					row_cursor[it.row] = nxt[CURSOR_W-1:0];
					r.drawn = 1'b1;
				end else begin
					n_skip++;
				end
			end
			OP_SET: begin
				n_set++;
				row_cursor[it.row] = it.column;
			end
			OP_CLEAR: begin
				n_clear++;
				for (int i = 0; i < FRAME_BYTES; i++) frame_mem[i] = '0;
			end
			OP_READ: begin
				n_read++;
				if (it.frame_addr < FRAME_BYTES) r.rd_byte = frame_mem[it.frame_addr];
			end
			default: begin
				n_spare++;
			end
		endcase
		r.cursor0 = row_cursor[0];
		r.cursor1 = row_cursor[1];
		return r;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (!idling || roll < 50) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic blit_cmd_t random_fields();
		blit_cmd_t it;
		it.op         = op_t'($urandom_range(0, 7));
		it.font_addr  = FADDR_W'($urandom_range(0, 4095));
		it.font_data  = BYTE_W'($urandom_range(0, 255));
		it.row        = 1'($urandom_range(0, 1));
		it.code       = BYTE_W'($urandom_range(0, 255));
		it.column     = CURSOR_W'($urandom_range(0, 255));
		it.frame_addr = FRADDR_W'($urandom_range(0, 511));
		return it;
	endfunction

	// Drives one item after an optional gap and waits until it is taken.
	task automatic issue_cmd(input blit_cmd_t it);
		int gap;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.valid         <= 1'b1;
		cmd.operation     <= it.op;
		cmd.font_address  <= it.font_addr;
		cmd.font_byte     <= it.font_data;
		cmd.text_row      <= it.row;
		cmd.symbol        <= it.code;
		cmd.cursor_column <= it.column;
		cmd.frame_address <= it.frame_addr;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		pending_results.push_back(blit_step(it));
		items_sent++;
	endtask

	task automatic load_glyph(input int g, input int width);
		blit_cmd_t it;
		for (int i = 0; i < GLYPH_STRIDE_DEF; i++) begin
			it = random_fields();
			it.op = OP_LOAD;
			it.font_addr = FADDR_W'(g * GLYPH_STRIDE_DEF + i);
			if (i == 0) it.font_data = BYTE_W'(width);
			issue_cmd(it);
		end
	endtask

	task automatic draw_code(input logic row, input logic [BYTE_W-1:0] code);
		blit_cmd_t it;
		it = random_fields();
		it.op = OP_DRAW;
		it.row = row;
		it.code = code;
		issue_cmd(it);
	endtask

	task automatic set_cursor(input logic row, input logic [CURSOR_W-1:0] column);
		blit_cmd_t it;
		it = random_fields();
		it.op = OP_SET;
		it.row = row;
		it.column = column;
		issue_cmd(it);
	endtask

	task automatic read_frame(input int addr);
		blit_cmd_t it;
		it = random_fields();
		it.op = OP_READ;
		it.frame_addr = FRADDR_W'(addr);
		issue_cmd(it);
	endtask

	task automatic send_plain(input op_t op);
		blit_cmd_t it;
		it = random_fields();
		it.op = op;
		issue_cmd(it);
	endtask

	// The frame starts out zero and both cursors at column zero.
	task automatic test_after_reset();
		read_frame(0);
		read_frame(FRAME_BYTES - 1);
		send_plain(OP_SPARE_LAST);
	endtask

	// Four glyphs are loaded whole: widths of twelve, zero, fourteen and the
	// maximum. Loads at and past the end of the store must be ignored.
	task automatic test_font_load();
		blit_cmd_t it;
		load_glyph(0, GLYPH_COLUMNS_DEF);
		load_glyph(1, 0);
		load_glyph(GLYPH_COUNT_DEF - 2, 14);
		load_glyph(GLYPH_COUNT_DEF - 1, 255);
		it = random_fields();
		it.op = OP_LOAD;
		it.font_addr = FADDR_W'(FONT_BYTES);
		issue_cmd(it);
		it.font_addr = '1;
		issue_cmd(it);
	endtask

	// Draws at the page edge, cursor saturation, codes outside the font,
	// then reads back the touched frame bytes.
	task automatic test_glyph_draw();
		draw_code(1'b0, FIRST_CODE);
		draw_code(1'b1, BYTE_W'(FIRST_CODE + GLYPH_COUNT_DEF - 1));
		draw_code(1'b1, BYTE_W'(FIRST_CODE + GLYPH_COUNT_DEF - 1));
		draw_code(1'b0, 8'd0);
		draw_code(1'b0, FIRST_CODE - 8'd1);
		draw_code(1'b1, BYTE_W'(FIRST_CODE + GLYPH_COUNT_DEF));
		draw_code(1'b1, 8'hFF);
		set_cursor(1'b0, 8'd120);
		draw_code(1'b0, FIRST_CODE);
		set_cursor(1'b0, 8'd127);
		draw_code(1'b0, BYTE_W'(FIRST_CODE + GLYPH_COUNT_DEF - 2));
		draw_code(1'b0, FIRST_CODE + 8'd1);
		read_frame(0);
		read_frame(11);
		read_frame(120);
		read_frame(PAGE_WIDTH_DEF - 1);
		read_frame(2 * PAGE_WIDTH_DEF - 1);
		read_frame(2 * PAGE_WIDTH_DEF);
		read_frame(3 * PAGE_WIDTH_DEF + 11);
		read_frame(FRAME_BYTES - 1);
	endtask

	// Clearing zeroes the frame but keeps both cursors; unused codes do nothing.
	task automatic test_clear_frame();
		send_plain(OP_CLEAR);
		read_frame(0);
		read_frame(3 * PAGE_WIDTH_DEF + 11);
		for (int o = OP_SPARE_FIRST; o <= OP_SPARE_LAST; o++) send_plain(op_t'(o));
		set_cursor(1'b0, 8'd0);
		set_cursor(1'b1, 8'd0);
	endtask

	// Mostly well-formed text drawing with cursor moves and reads, mixed with
	// font reloads, stray loads, clears and unused codes.
	task automatic test_random();
		blit_cmd_t it;
		int roll, g;
		while (items_sent < ITEM_TARGET) begin
			idling = ((items_sent / 100) % 3) != 2;
			roll = $urandom_range(0, 99);
			it = random_fields();
			if (roll < 3) begin
				load_glyph($urandom_range(0, GLYPH_COUNT_DEF - 1),
					($urandom_range(0, 9) == 0) ? 255 : $urandom_range(1, 14));
				continue;
			end
			if (roll < 16) begin
				it.op = OP_LOAD;
				if ($urandom_range(0, 9) < 7)
					it.font_addr = FADDR_W'($urandom_range(0, FONT_BYTES - 1));
			end else if (roll < 52) begin
				it.op = OP_DRAW;
				if ($urandom_range(0, 4) != 0) begin
					do g = $urandom_range(0, GLYPH_COUNT_DEF - 1); while (!glyph_ready(g));
					it.code = BYTE_W'(FIRST_CODE + g);
				end else if (in_font(it.code) && !glyph_ready(it.code - FIRST_CODE)) begin
					it.code = BYTE_W'($urandom_range(0, FIRST_CODE - 1));
				end
			end else if (roll < 64) begin
				it.op = OP_SET;
				if ($urandom_range(0, 4) != 0)
					it.column = CURSOR_W'($urandom_range(0, PAGE_WIDTH_DEF + 2));
			end else if (roll < 66) begin
				it.op = OP_CLEAR;
			end else if (roll < 94) begin
				it.op = OP_READ;
			end else begin
				it.op = op_t'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
			end
			issue_cmd(it);
		end
		idling = 1'b1;
	endtask

	// Result side: random stalls, and compare each item with the oldest
	// prediction.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (idling && $urandom_range(0, 3) == 0) begin
			stall_left <= idle_len();
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (res.valid && res.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("result item arrived with no command waiting for it");
			end else begin
				want = pending_results.pop_front();
				if (res.read_byte !== want.rd_byte ||
					res.row_zero_cursor !== want.cursor0 ||
					res.row_one_cursor !== want.cursor1 ||
					res.glyph_drawn !== want.drawn) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("result %0d: expected byte %h cursors %0d/%0d drawn %b",
							results_seen, want.rd_byte, want.cursor0, want.cursor1,
							want.drawn);
						$display("result %0d: got byte %h cursors %0d/%0d drawn %b",
							results_seen, res.read_byte, res.row_zero_cursor,
							res.row_one_cursor, res.glyph_drawn);
					end
				end
			end
		end
	end

	// Watchdog: ends the run if no item moves on either side for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd.valid && cmd.ready) || (res.valid && res.ready)) quiet = 0;
			else quiet++;
		end
		$display("no item moved for %0d cycles", QUIET_LIMIT);
		$display("glyph_blit_page_framebuffer test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd.valid = 1'b0;
		cmd.operation = OP_LOAD;
		cmd.font_address = '0;
		cmd.font_byte = '0;
		cmd.text_row = 1'b0;
		cmd.symbol = '0;
		cmd.cursor_column = '0;
		cmd.frame_address = '0;
		res.ready = 1'b0;
		for (int i = 0; i < FONT_BYTES; i++) begin
			font_mem[i] = '0;
			font_loaded[i] = 1'b0;
		end
		for (int i = 0; i < FRAME_BYTES; i++) frame_mem[i] = '0;
		row_cursor[0] = '0;
		row_cursor[1] = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_after_reset();
		test_font_load();
		test_glyph_draw();
		test_clear_frame();
		test_random();

		@(negedge clk);
		cmd.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d items, %0d results checked: %0d loads, %0d draws",
			items_sent, results_seen, n_load, n_draw);
		$display("(%0d clipped, %0d saturated), %0d ignored codes, %0d cursor sets,",
			n_clip, n_sat, n_skip, n_set);
		$display("%0d clears, %0d frame reads, %0d unused codes, %0d mismatches",
			n_clear, n_read, n_spare, mismatches);
		if (mismatches == 0) begin
			$display("glyph_blit_page_framebuffer test passed");
		end else begin
			$display("glyph_blit_page_framebuffer test failed");
		end
		$finish;
	end

endmodule
